// ===== sv/pulse_beat_rate_meter_macros.svh =====
// Assertion helpers for the beat rate meter
`ifndef PULSE_BEAT_RATE_METER_MACROS_SVH
`define PULSE_BEAT_RATE_METER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbrm check failed");

// next-cycle implication
`define PBRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbrm check failed");

`endif

// ===== sv/pbrm_pkg.sv =====
`default_nettype none

package pbrm_pkg;

    localparam int THR_W    = 10;
    localparam int CNT_W    = 16;
    localparam int SCALE_W  = 4;
    localparam int RATE_W   = 10;
    localparam int PROD_W   = CNT_W + SCALE_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // register indexes, paddr[4:2]
    localparam logic [2:0] REG_LOW    = 3'd0;
    localparam logic [2:0] REG_HIGH   = 3'd1;
    localparam logic [2:0] REG_WINDOW = 3'd2;
    localparam logic [2:0] REG_SCALE  = 3'd3;
    localparam logic [2:0] REG_ALERT  = 3'd4;

    localparam logic [THR_W-1:0]   LOW_RST    = 10'd200;
    localparam logic [THR_W-1:0]   HIGH_RST   = 10'd1000;
    localparam logic [CNT_W-1:0]   WINDOW_RST = 16'd1500;
    localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd4;
    localparam logic [RATE_W-1:0]  ALERT_RST  = 10'd100;

    localparam logic [RATE_W-1:0] RATE_MAX  = 10'd999;
    localparam logic [7:0]        CHAR_ZERO = 8'h30;
    localparam logic [7:0]        CHAR_NL   = 8'h0A;

    typedef struct packed {
        logic [THR_W-1:0] low;
        logic [THR_W-1:0] high;
        logic [CNT_W-1:0] window;
    } front_cfg_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [RATE_W-1:0]  alert_limit;
    } back_cfg_t;

    // one finished window: beat count waiting for conversion
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] beats;
    } rpt_t;

endpackage

`default_nettype wire

// ===== sv/pbrm_front.sv =====
`default_nettype none

module pbrm_front
    import pbrm_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire front_cfg_t             cfg,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   q_full,
    output rpt_t                        push
);

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [CNT_W-1:0]       beats_reg, beats_next;
    logic [CNT_W-1:0]       seen_reg, seen_next;
    logic [CMP_W-1:0]       prev_x, samp_x, low_x, high_x;
    logic                   accept, hit, window_done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign prev_x = CMP_W'(prev_reg);
    assign samp_x = CMP_W'(sample);
    assign low_x  = CMP_W'(cfg.low);
    assign high_x = CMP_W'(cfg.high);
    assign hit    = (prev_x < low_x) && (samp_x > high_x);

    // both counters stick at all-ones
    assign beats_next  = (hit && beats_reg != '1) ? beats_reg + CNT_W'(1) : beats_reg;
    assign seen_next   = (seen_reg != '1) ? seen_reg + CNT_W'(1) : seen_reg;
    assign window_done = seen_next >= cfg.window;

    assign push.valid = accept && window_done;
    assign push.beats = beats_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            beats_reg <= '0;
            seen_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg <= sample;
            if (window_done)
            begin
                beats_reg <= '0;
                seen_reg  <= '0;
            end
            else
            begin
                beats_reg <= beats_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/pbrm_queue.sv =====
`default_nettype none

module pbrm_queue
    import pbrm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire rpt_t push,
    output logic      full,
    input  wire logic pop,
    output rpt_t      head
);

    logic [CNT_W-1:0]   mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign full       = count_reg == Q_CNT_W'(Q_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.beats = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.beats;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + Q_CNT_W'(1);
                2'b01:   count_reg <= count_reg - Q_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/pbrm_back.sv =====
`default_nettype none

module pbrm_back
    import pbrm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire back_cfg_t cfg,
    input  wire rpt_t      head,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [7:0]     text_char,
    output logic           alert,
    output logic           saturated,
    output logic           last_char
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CLAMP,
        S_HUN,
        S_REM,
        S_TEN,
        S_OUT
    } state_t;

    localparam logic [1:0] SLOT_HUN  = 2'd0;
    localparam logic [1:0] SLOT_TEN  = 2'd1;
    localparam logic [1:0] SLOT_UNIT = 2'd2;
    localparam logic [1:0] SLOT_NL   = 2'd3;

    state_t              state_reg;
    logic [CNT_W-1:0]    beats_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [3:0]          hun_reg, ten_reg;
    logic [6:0]          rem_reg;
    logic [1:0]          slot_reg, slot_next;
    logic                valid_reg, sat_reg, alert_reg, last_reg;
    logic [7:0]          char_reg;

    logic [15:0]         hun_prod;
    logic [RATE_W-1:0]   rem_full;
    logic [14:0]         ten_prod;
    logic [6:0]          unit_full;
    logic [7:0]          slot_char;

    assign pop = (state_reg == S_IDLE) && head.valid;

    // x*41 >> 12 and x*205 >> 11 give x/100 and x/10 exactly over the ranges used
    assign hun_prod  = 16'(rate_reg) * 16'd41;
    assign rem_full  = rate_reg - RATE_W'(hun_reg) * RATE_W'(100);
    assign ten_prod  = 15'(rem_reg) * 15'd205;
    assign unit_full = rem_reg - 7'(ten_reg) * 7'd10;

    assign slot_next = slot_reg + 2'd1;

    always_comb
    begin
        case (slot_next)
            SLOT_HUN:  slot_char = CHAR_ZERO + 8'(hun_reg);
            SLOT_TEN:  slot_char = CHAR_ZERO + 8'(ten_reg);
            SLOT_UNIT: slot_char = CHAR_ZERO + 8'(unit_full[3:0]);
            default:   slot_char = CHAR_NL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            beats_reg <= '0;
            prod_reg  <= '0;
            rate_reg  <= '0;
            hun_reg   <= '0;
            ten_reg   <= '0;
            rem_reg   <= '0;
            slot_reg  <= SLOT_HUN;
            valid_reg <= 1'b0;
            sat_reg   <= 1'b0;
            alert_reg <= 1'b0;
            last_reg  <= 1'b0;
            char_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        beats_reg <= head.beats;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(beats_reg) * PROD_W'(cfg.scale);
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (prod_reg > PROD_W'(RATE_MAX))
                    begin
                        rate_reg <= RATE_MAX;
                        sat_reg  <= 1'b1;
                    end
                    else
                    begin
                        rate_reg <= prod_reg[RATE_W-1:0];
                        sat_reg  <= 1'b0;
                    end
                    state_reg <= S_HUN;
                end
                S_HUN:
                begin
                    hun_reg   <= hun_prod[15:12];
                    alert_reg <= rate_reg > cfg.alert_limit;
                    state_reg <= S_REM;
                end
                S_REM:
                begin
                    rem_reg   <= rem_full[6:0];
                    state_reg <= S_TEN;
                end
                S_TEN:
                begin
                    ten_reg   <= ten_prod[14:11];
                    slot_reg  <= SLOT_HUN;
                    char_reg  <= CHAR_ZERO + 8'(hun_reg);
                    last_reg  <= 1'b0;
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (slot_reg == SLOT_NL)
                        begin
                            valid_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            slot_reg <= slot_next;
                            char_reg <= slot_char;
                            last_reg <= slot_next == SLOT_NL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign text_char = char_reg;
    assign alert     = alert_reg;
    assign saturated = sat_reg;
    assign last_char = last_reg;

endmodule

`default_nettype wire

// ===== sv/pulse_beat_rate_meter.sv =====
`default_nettype none

`include "pulse_beat_rate_meter_macros.svh"

// Pulse beat rate meter. Takes one sensor sample per input word and counts a beat
// when the previous sample was below low_threshold and the current one is above
// high_threshold. Every window_samples samples the beat count is scaled by
// rate_scale, clamped to 999 (saturated set) and sent out as four words: hundreds,
// tens and units digit in ASCII, then a newline with last_char set; alert marks a
// rate above alert_limit. A new sample is taken every cycle while the two-entry
// report queue between the sample counter and the converter has room. Each report
// passes the converter's fetch, then staged multiply, clamp, hundreds, remainder
// and tens steps, then one word per cycle while out_ready is high; windows shorter
// than a conversion hold off input once the queue is full. Registers sit at byte
// addresses 0, 4, 8, 12, 16 and read back their value.
module pulse_beat_rate_meter
    import pbrm_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  text_char,
    output logic                        alert,
    output logic                        saturated,
    output logic                        last_char
);

    logic [THR_W-1:0]   low_reg, high_reg;
    logic [CNT_W-1:0]   window_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [RATE_W-1:0]  alert_lim_reg;
    logic               wr_en;

    front_cfg_t f_cfg;
    back_cfg_t  b_cfg;
    rpt_t       push, head;
    logic       q_full, pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= LOW_RST;
            high_reg      <= HIGH_RST;
            window_reg    <= WINDOW_RST;
            scale_reg     <= SCALE_RST;
            alert_lim_reg <= ALERT_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_LOW:    low_reg       <= pwdata[THR_W-1:0];
                REG_HIGH:   high_reg      <= pwdata[THR_W-1:0];
                REG_WINDOW: window_reg    <= pwdata[CNT_W-1:0];
                REG_SCALE:  scale_reg     <= pwdata[SCALE_W-1:0];
                REG_ALERT:  alert_lim_reg <= pwdata[RATE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_LOW:    prdata = DATA_W'(low_reg);
            REG_HIGH:   prdata = DATA_W'(high_reg);
            REG_WINDOW: prdata = DATA_W'(window_reg);
            REG_SCALE:  prdata = DATA_W'(scale_reg);
            REG_ALERT:  prdata = DATA_W'(alert_lim_reg);
            default:    prdata = '0;
        endcase
    end

    assign f_cfg.low         = low_reg;
    assign f_cfg.high        = high_reg;
    assign f_cfg.window      = window_reg;
    assign b_cfg.scale       = scale_reg;
    assign b_cfg.alert_limit = alert_lim_reg;

    pbrm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (f_cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .q_full   (q_full),
        .push     (push)
    );

    pbrm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    pbrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (b_cfg),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .alert     (alert),
        .saturated (saturated),
        .last_char (last_char)
    );

    // newline closes every report, digits elsewhere
    `PBRM_ASSERT_NOW(a_nl_last, out_valid && last_char, text_char == CHAR_NL)
    `PBRM_ASSERT_NOW(a_digit, out_valid && !last_char,
                     text_char >= CHAR_ZERO && text_char <= (CHAR_ZERO + 8'd9))
    // clamped reports read 999
    `PBRM_ASSERT_NOW(a_sat_nines, out_valid && saturated,
                     text_char == (CHAR_ZERO + 8'd9) || text_char == CHAR_NL)
    // a report is never cut short
    `PBRM_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last_char, out_valid)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pbrm_pkg::*;

    localparam int SAMPLE_W     = 10;
    localparam int DRAIN_GAP    = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 21;

    typedef struct packed {
        logic [7:0] code;
        logic       alert;
        logic       saturated;
        logic       last_char;
    } report_word_t;

    // Predicts the report words from the accepted samples and checks the output stream
    class beat_report_board;
        logic [THR_W-1:0]    low_thr;
        logic [THR_W-1:0]    high_thr;
        logic [CNT_W-1:0]    window;
        logic [SCALE_W-1:0]  scale;
        logic [RATE_W-1:0]   alert_lim;
        logic [SAMPLE_W-1:0] prev;
        logic [CNT_W-1:0]    beats;
        logic [CNT_W-1:0]    seen;
        report_word_t        expected_words[$];
        int unsigned         errors;

        function new();
            low_thr   = LOW_RST;
            high_thr  = HIGH_RST;
            window    = WINDOW_RST;
            scale     = SCALE_RST;
            alert_lim = ALERT_RST;
            prev      = '0;
            beats     = '0;
            seen      = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_LOW:    low_thr   = val[THR_W-1:0];
                REG_HIGH:   high_thr  = val[THR_W-1:0];
                REG_WINDOW: window    = val[CNT_W-1:0];
                REG_SCALE:  scale     = val[SCALE_W-1:0];
                REG_ALERT:  alert_lim = val[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            int unsigned rate;
            logic        over;
            logic        loud;
            if (prev < low_thr && s > high_thr && beats != 16'hFFFF)
                beats++;
            prev = s;
            if (seen != 16'hFFFF)
                seen++;
            // a window cut short by a register write reports on the next word
            if (seen < window)
                return;
            rate = int'(beats) * int'(scale);
            over = (rate > RATE_MAX);
            if (over)
                rate = RATE_MAX;
            loud = (rate > alert_lim);
            expected_words.push_back(report_word_t'{CHAR_ZERO + 8'(rate / 100), loud, over, 1'b0});
            expected_words.push_back(report_word_t'{CHAR_ZERO + 8'((rate / 10) % 10), loud, over,
                                                    1'b0});
            expected_words.push_back(report_word_t'{CHAR_ZERO + 8'(rate % 10), loud, over, 1'b0});
            expected_words.push_back(report_word_t'{CHAR_NL, loud, over, 1'b1});
            beats = '0;
            seen  = '0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(report_word_t got);
            report_word_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing pending: char %h", got.code));
                return;
            end
            want = expected_words.pop_front();
            if (got.code != want.code || got.alert != want.alert ||
                got.saturated != want.saturated || got.last_char != want.last_char)
                report_mismatch($sformatf("char %h/%h alert %b/%b sat %b/%b last %b/%b (got/want)",
                                          got.code, want.code, got.alert, want.alert,
                                          got.saturated, want.saturated,
                                          got.last_char, want.last_char));
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample    = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [7:0]          text_char;
    logic                alert;
    logic                saturated;
    logic                last_char;

    beat_report_board board = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned holds_asked   = 0;
    int unsigned holds_granted = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    pulse_beat_rate_meter #(
        .SAMPLE_BITS (SAMPLE_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .alert     (alert),
        .saturated (saturated),
        .last_char (last_char)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receive side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_word(report_word_t'{text_char, alert, saturated, last_char});
        if (holds_granted != holds_asked)
        begin
            holds_granted <= holds_asked;
            hold_left     <= HOLD_CYCLES;
            out_ready     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pulse_beat_rate_meter test failed");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    // called at a clock edge; returns at the edge where the word is taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_sample(s);
    endtask

    task automatic wait_reports_out();
        in_valid <= 1'b0;
        while (board.expected_words.size() != 0)
            @(posedge clk);
        // counting may still be busy on words that gave no report
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // mostly dips below the low threshold and peaks above the high one
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4 && board.low_thr != 0)
            return SAMPLE_W'($urandom_range(int'(board.low_thr) - 1, 0));
        if (pick < 8 && board.high_thr != 10'h3FF)
            return SAMPLE_W'($urandom_range(1023, int'(board.high_thr) + 1));
        return SAMPLE_W'($urandom_range(1023));
    endfunction

    task automatic pick_settings();
        logic [THR_W-1:0] lo;
        logic [THR_W-1:0] hi;
        lo = ($urandom_range(9) == 0) ? THR_W'($urandom_range(1023))
                                      : THR_W'($urandom_range(600, 50));
        hi = ($urandom_range(9) == 0) ? THR_W'($urandom_range(1023))
                                      : THR_W'($urandom_range(1023, lo));
        write_reg(REG_LOW, 32'(lo));
        write_reg(REG_HIGH, 32'(hi));
        write_reg(REG_WINDOW, ($urandom_range(6) == 0) ? $urandom_range(40) : $urandom_range(8, 1));
        write_reg(REG_SCALE, $urandom_range(15));
        write_reg(REG_ALERT, ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(60));
    endtask

    // every word is a beat: thresholds wide open, one word first to close the open window
    task automatic dense_burst(input logic [15:0] span, input logic [3:0] factor,
                               input logic [9:0] limit);
        write_reg(REG_LOW, 32'h3FF);
        write_reg(REG_HIGH, 32'h000);
        write_reg(REG_SCALE, 32'(factor));
        write_reg(REG_ALERT, 32'(limit));
        write_reg(REG_WINDOW, 1);
        send_sample(10'd1);
        wait_reports_out();
        write_reg(REG_WINDOW, 32'(span));
        repeat (span) send_sample(SAMPLE_W'($urandom_range(1022, 1)));
        wait_reports_out();
    endtask

    initial
    begin : stimulus
        int mode;
        int phase;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // longest window: nothing reported yet, one beat counted
        write_reg(REG_WINDOW, 32'hFFFF);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd5);
        wait_reports_out();

        // zero window cuts the open window short, then reports on every word
        write_reg(REG_WINDOW, 0);
        write_reg(REG_SCALE, 15);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1000);
        send_sample(10'd199);
        send_sample(10'd1001);
        send_sample(10'd200);
        send_sample(10'd1001);
        wait_reports_out();

        // zero scale gives rate 0 despite beats
        write_reg(REG_LOW, 32'h3FF);
        write_reg(REG_HIGH, 0);
        write_reg(REG_WINDOW, 1);
        write_reg(REG_SCALE, 0);
        write_reg(REG_ALERT, 0);
        send_sample(10'd1);
        send_sample(10'd512);
        wait_reports_out();

        write_reg(REG_SCALE, 1);
        send_sample(10'd1023);
        send_sample(10'd0);
        wait_reports_out();

        write_reg(REG_WINDOW, 2);
        write_reg(REG_SCALE, 15);
        write_reg(REG_ALERT, 14);
        send_sample(10'd3);
        send_sample(10'd7);
        send_sample(10'd9);
        send_sample(10'd11);
        wait_reports_out();

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (phase = 0; phase < 3; phase++)
            begin
                pick_settings();
                for (k = 0; k < PHASE_WORDS; k++)
                begin
                    if (mode == 1 && phase == 0 && k == 12)
                        wait_reports_out();
                    send_sample(next_sample());
                end
                wait_reports_out();
            end
            case (mode)
                0: dense_burst(16'd70, 4'd15, 10'd500);
                1: dense_burst(16'd111, 4'd9, 10'd999);
                default:
                begin
                    // one report per word while the output is held off: the queue fills
                    pick_settings();
                    write_reg(REG_WINDOW, 1);
                    holds_asked <= holds_asked + 1;
                    repeat (40) send_sample(next_sample());
                    wait_reports_out();
                end
            endcase
        end

        wait_reports_out();
        if (board.errors == 0 && board.expected_words.size() == 0)
            $display("pulse_beat_rate_meter test passed");
        else
            $display("pulse_beat_rate_meter test failed");
        $finish;
    end

endmodule
